FILE: src/hsf_pkg.sv
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared types, codes and defaults of the stereo FIR filter block.
// ----------------------------------------------------------------------------
package hsf_pkg;

	localparam int MAX_TAPS_DEF      = 32;
	localparam int MAX_POSITIONS_DEF = 256;

	// item commands
	localparam logic [1:0] CMD_FILTER   = 2'd0;
	localparam logic [1:0] CMD_WR_LEFT  = 2'd1;
	localparam logic [1:0] CMD_WR_RIGHT = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_POSITION_SELECT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAPS_IN_USE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POSITIONS_IN_USE = 2'd2;

	localparam logic [7:0] POSITION_SELECT_RST  = 8'd0;
	localparam logic [5:0] TAPS_IN_USE_RST      = 6'd32;
	localparam logic [8:0] POSITIONS_IN_USE_RST = 9'd168;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [15:0] sample_in;
		logic               block_start;
		logic [12:0]        coef_address;
		logic signed [15:0] coef_value;
	} item_t;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_HOLD
	} fsm_state_t;

	typedef struct packed {
		logic accept;
		logic start;
		logic issue;
		logic load_out;
	} ctrl_t;

	typedef struct packed {
		logic last_tap;
	} stat_t;

endpackage

FILE: src/hrtf_stereo_fir.sv
// ----------------------------------------------------------------------------
// hrtf_stereo_fir
// Mono to stereo FIR filter with a per-position kernel store.
// ----------------------------------------------------------------------------
// sequence: one tap per cycle in RUN on the single read port of each
//   coefficient store, products registered and summed, a drain, then a rounded
//   result load held while a pending result stalls; write items need no run
// reset: control, configuration and history fill count cleared at once;
//   coefficient store is undefined until written
module hrtf_stereo_fir #(
	parameter int MAX_TAPS      = hsf_pkg::MAX_TAPS_DEF,
	parameter int MAX_POSITIONS = hsf_pkg::MAX_POSITIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  hsf_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output hsf_pkg::result_t               result,
	input  logic                           cfg_write,
	input  logic [hsf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hsf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hsf_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	hsf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.command      (item.command),
		.result_stall (result_stall),
		.stat         (stat),
		.ctrl         (ctrl),
		.item_stall   (item_stall),
		.result_valid (result_valid)
	);

	hsf_datapath #(
		.MAX_TAPS      (MAX_TAPS),
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.ctrl      (ctrl),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.result    (result)
	);

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |-> (!result_valid || !result_stall))
		else $error("result overwritten while pending");

	// no item taken while taps are being issued
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.issue |-> item_stall)
		else $error("item intake during filter run");

	// a filter start is followed by the first tap
	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> ctrl.issue)
		else $error("filter run did not follow start");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.start, ctrl.issue, ctrl.load_out}))
		else $error("conflicting datapath commands");

endmodule

FILE: src/hsf_ram.sv
// ----------------------------------------------------------------------------
// hsf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hsf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/hsf_datapath.sv
// ----------------------------------------------------------------------------
// hsf_datapath
// Configuration registers, coefficient and history stores, two MAC lanes,
// rounding and the result register.
// ----------------------------------------------------------------------------
module hsf_datapath #(
	parameter int MAX_TAPS      = hsf_pkg::MAX_TAPS_DEF,
	parameter int MAX_POSITIONS = hsf_pkg::MAX_POSITIONS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hsf_pkg::item_t                      item,
	input  hsf_pkg::ctrl_t                      ctrl,
	input  logic                                cfg_write,
	input  logic [hsf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hsf_pkg::CFG_DATA_W-1:0]      cfg_data,
	output hsf_pkg::stat_t                      stat,
	output hsf_pkg::result_t                    result
);
	import hsf_pkg::*;

	localparam int STORE_DEPTH = MAX_TAPS * MAX_POSITIONS;
	localparam int SA_W        = $clog2(STORE_DEPTH);
	localparam int TAP_W       = $clog2(MAX_TAPS + 1);
	localparam int POS_W       = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
	localparam int HP_W        = $clog2(MAX_TAPS);
	localparam int HIST_DEPTH  = 1 << HP_W;
	localparam int ACC_W       = 32 + $clog2(MAX_TAPS);

	logic [7:0] position_select_q;
	logic [5:0] taps_in_use_q;
	logic [8:0] positions_in_use_q;

	logic [TAP_W-1:0]       taps_eff;
	logic [31:0]            npos_eff;
	logic [POS_W-1:0]       pos_eff;
	logic [POS_W+TAP_W-1:0] base_full;
	logic [TAP_W-1:0]       fill_base;
	logic [31:0]            waddr_ext;
	logic                   waddr_ok;

	logic [SA_W-1:0]  base_q;
	logic [TAP_W-1:0] taps_last_q;
	logic [TAP_W-1:0] fill_q;
	logic [TAP_W-1:0] fill_cur_q;
	logic [TAP_W-1:0] j_q;
	logic [HP_W-1:0]  wp_q;

	logic [15:0] coef_l_rd;
	logic [15:0] coef_r_rd;
	logic [15:0] hist_rd;
	logic [15:0] hist_m;

	logic                     valid_s1;
	logic                     tapok_s1;
	logic                     valid_s2;
	logic signed [31:0]       prod_l_s2;
	logic signed [31:0]       prod_r_s2;
	logic signed [ACC_W-1:0]  acc_l_q;
	logic signed [ACC_W-1:0]  acc_r_q;

	function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0] s;
		logic signed [ACC_W:0] q;
		s = (ACC_W+1)'(a) + (ACC_W+1)'(16384);
		q = s >>> 15;
		if (q > (ACC_W+1)'(32767)) begin
			return 16'sh7fff;
		end else if (q < -(ACC_W+1)'(32768)) begin
			return 16'sh8000;
		end
		return q[15:0];
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_select_q  <= POSITION_SELECT_RST;
			taps_in_use_q      <= TAPS_IN_USE_RST;
			positions_in_use_q <= POSITIONS_IN_USE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_POSITION_SELECT:  position_select_q  <= cfg_data[7:0];
				CFG_TAPS_IN_USE:      taps_in_use_q      <= cfg_data[5:0];
				CFG_POSITIONS_IN_USE: positions_in_use_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// kernel selection
	always_comb begin
		if (taps_in_use_q == 6'd0) begin
			taps_eff = TAP_W'(1);
		end else if (32'(taps_in_use_q) > 32'(MAX_TAPS)) begin
			taps_eff = TAP_W'(MAX_TAPS);
		end else begin
			taps_eff = TAP_W'(taps_in_use_q);
		end
		npos_eff = (32'(positions_in_use_q) > 32'(MAX_POSITIONS)) ?
			32'(MAX_POSITIONS) : 32'(positions_in_use_q);
		pos_eff  = (32'(position_select_q) < npos_eff) ? POS_W'(position_select_q) : '0;
		base_full = pos_eff * taps_eff;
		fill_base = item.block_start ? '0 : fill_q;
		waddr_ext = 32'(item.coef_address);
		waddr_ok  = waddr_ext < 32'(STORE_DEPTH);
	end

	// sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			wp_q   <= '0;
			j_q    <= '0;
		end else if (ctrl.start) begin
			fill_q <= (32'(fill_base) >= 32'(MAX_TAPS - 1)) ?
				TAP_W'(MAX_TAPS - 1) : fill_base + TAP_W'(1);
			wp_q   <= wp_q + HP_W'(1);
			j_q    <= '0;
		end else if (ctrl.issue) begin
			j_q <= j_q + TAP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			base_q      <= base_full[SA_W-1:0];
			taps_last_q <= taps_eff - TAP_W'(1);
			fill_cur_q  <= fill_base;
		end
	end

	assign stat.last_tap = (j_q == taps_last_q);

	hsf_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_coef_left (
		.clk   (clk),
		.we    (ctrl.accept && item.command == CMD_WR_LEFT && waddr_ok),
		.waddr (waddr_ext[SA_W-1:0]),
		.wdata (item.coef_value),
		.raddr (base_q + SA_W'(j_q)),
		.rdata (coef_l_rd)
	);

	hsf_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_coef_right (
		.clk   (clk),
		.we    (ctrl.accept && item.command == CMD_WR_RIGHT && waddr_ok),
		.waddr (waddr_ext[SA_W-1:0]),
		.wdata (item.coef_value),
		.raddr (base_q + SA_W'(j_q)),
		.rdata (coef_r_rd)
	);

	// newest sample sits at wp_q - 1 once the filter run starts
	hsf_ram #(.WIDTH(16), .DEPTH(HIST_DEPTH)) u_history (
		.clk   (clk),
		.we    (ctrl.start),
		.waddr (wp_q),
		.wdata (item.sample_in),
		.raddr (wp_q - HP_W'(1) - j_q[HP_W-1:0]),
		.rdata (hist_rd)
	);

	// mac pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			tapok_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.issue;
			tapok_s1 <= (j_q <= fill_cur_q);
			valid_s2 <= valid_s1;
		end
	end

	assign hist_m = tapok_s1 ? hist_rd : '0;

	always_ff @(posedge clk) begin
		prod_l_s2 <= $signed(coef_l_rd) * $signed(hist_m);
		prod_r_s2 <= $signed(coef_r_rd) * $signed(hist_m);
		if (ctrl.start) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (valid_s2) begin
			acc_l_q <= acc_l_q + ACC_W'(prod_l_s2);
			acc_r_q <= acc_r_q + ACC_W'(prod_r_s2);
		end
		if (ctrl.load_out) begin
			result.left_sample  <= round_sat(acc_l_q);
			result.right_sample <= round_sat(acc_r_q);
		end
	end

endmodule

FILE: src/hsf_ctrl.sv
// ----------------------------------------------------------------------------
// hsf_ctrl
// Controller: item intake, tap sequencing, pipeline drain and result handoff.
// ----------------------------------------------------------------------------
module hsf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic [1:0]     command,
	input  logic           result_stall,
	input  hsf_pkg::stat_t stat,
	output hsf_pkg::ctrl_t ctrl,
	output logic           item_stall,
	output logic           result_valid
);
	import hsf_pkg::*;

	fsm_state_t state_q;
	fsm_state_t state_d;
	logic       drain_q;
	logic       result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ctrl       = '0;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					ctrl.accept = 1'b1;
					if (command == CMD_FILTER) begin
						ctrl.start = 1'b1;
						state_d    = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				ctrl.issue = 1'b1;
				if (stat.last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!result_valid_q || !result_stall) begin
					ctrl.load_out = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			drain_q <= (state_q == ST_DRAIN) ? !drain_q : 1'b0;
			if (ctrl.load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

endmodule
